// ===== rtl/fo_pkg.sv =====
// Package for frame_orthonormalize: word types and widths.
// No dependencies.
package fo_pkg;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam int PW = 2 * CW + 1;
  localparam int BW = 4 * CW + 2;
  localparam int SW = 2 * BW + 2;
  localparam int LW = BW + 1;
  localparam int QB = FB + 1;

  typedef struct packed {
    logic signed [CW-1:0] right_x;
    logic signed [CW-1:0] right_y;
    logic signed [CW-1:0] right_z;
    logic signed [CW-1:0] up_x;
    logic signed [CW-1:0] up_y;
    logic signed [CW-1:0] up_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] unit_right_x;
    logic signed [CW-1:0] unit_right_y;
    logic signed [CW-1:0] unit_right_z;
    logic signed [CW-1:0] unit_up_x;
    logic signed [CW-1:0] unit_up_y;
    logic signed [CW-1:0] unit_up_z;
    logic signed [CW-1:0] unit_back_x;
    logic signed [CW-1:0] unit_back_y;
    logic signed [CW-1:0] unit_back_z;
    logic                 degenerate;
  } out_word_t;

  typedef struct packed {
    logic          neg;
    logic [BW-1:0] mag;
  } comp_t;

endpackage

// ===== rtl/fo_lane.sv =====
// One normalize lane: pipelined sum of squares, bit-per-stage square root,
// and three bit-per-stage scaled dividers. Depends on fo_pkg.
module fo_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  fo_pkg::comp_t [2:0]     vec_i,
  output logic                    vld_o,
  output logic                    zero_o,
  output logic [2:0][fo_pkg::CW-1:0] unit_o
);
  localparam int RS = fo_pkg::LW;
  localparam int NS = 2 + RS + fo_pkg::QB;
  localparam int DW = fo_pkg::BW + fo_pkg::FB + 1;
  localparam int MW = 3 * fo_pkg::CW;
  localparam int HW = MW / 2;

  logic [NS-1:0] vld_q;
  fo_pkg::comp_t [NS-1:0][2:0] v_q;
  logic [fo_pkg::SW-1:0] rem_q [RS+1];
  logic [fo_pkg::LW-1:0] root_q [RS+1];
  logic [2*HW-1:0] pp_q [3][3];
  logic [fo_pkg::SW-1:0] sq_sum;
  logic [fo_pkg::LW-1:0] len_q [fo_pkg::QB+1];
  logic [DW-1:0] drem_q [fo_pkg::QB+1][3];
  logic [fo_pkg::QB-1:0] quo_q [fo_pkg::QB+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  // stage 0: half-width partial products of each square
  always_ff @(posedge clk_i) begin
    v_q[0] <= vec_i;
    for (int i = 0; i < 3; i++) begin
      pp_q[i][0] <= (2*HW)'(vec_i[i].mag[MW-1:HW] * vec_i[i].mag[MW-1:HW]);
      pp_q[i][1] <= (2*HW)'(vec_i[i].mag[MW-1:HW] * vec_i[i].mag[HW-1:0]);
      pp_q[i][2] <= (2*HW)'(vec_i[i].mag[HW-1:0] * vec_i[i].mag[HW-1:0]);
    end
  end

  always_comb begin
    sq_sum = '0;
    for (int i = 0; i < 3; i++) begin
      sq_sum = sq_sum + (fo_pkg::SW'(pp_q[i][0]) << (2 * HW))
                      + (fo_pkg::SW'(pp_q[i][1]) << (HW + 1))
                      + fo_pkg::SW'(pp_q[i][2]);
    end
  end

  // stage 1: sum
  always_ff @(posedge clk_i) begin
    v_q[1] <= v_q[0];
    rem_q[0] <= sq_sum;
    root_q[0] <= '0;
  end

  // root stages: restoring, one result bit per stage
  for (genvar s = 0; s < RS; s++) begin : g_sqrt
    localparam int B = RS - 1 - s;
    logic [fo_pkg::SW-1:0] trial;
    assign trial = (fo_pkg::SW'(root_q[s]) << (B + 1)) + (fo_pkg::SW'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      v_q[s+2] <= v_q[s+1];
      if (trial <= rem_q[s]) begin
        rem_q[s+1] <= rem_q[s] - trial;
        root_q[s+1] <= root_q[s] | (fo_pkg::LW'(1) << B);
      end else begin
        rem_q[s+1] <= rem_q[s];
        root_q[s+1] <= root_q[s];
      end
    end
  end

  always_comb begin
    len_q[0] = root_q[RS];
    for (int i = 0; i < 3; i++) begin
      drem_q[0][i] = DW'(v_q[RS+1][i].mag) << fo_pkg::FB;
      quo_q[0][i] = '0;
    end
  end

  // divider stages: one quotient bit per stage
  for (genvar k = 0; k < fo_pkg::QB; k++) begin : g_div
    localparam int B = fo_pkg::QB - 1 - k;
    always_ff @(posedge clk_i) begin
      v_q[RS+2+k] <= v_q[RS+1+k];
      len_q[k+1] <= len_q[k];
      for (int i = 0; i < 3; i++) begin
        if ((DW'(len_q[k]) << B) <= drem_q[k][i]) begin
          drem_q[k+1][i] <= drem_q[k][i] - (DW'(len_q[k]) << B);
          quo_q[k+1][i] <= quo_q[k][i] | (fo_pkg::QB'(1) << B);
        end else begin
          drem_q[k+1][i] <= drem_q[k][i];
          quo_q[k+1][i] <= quo_q[k][i];
        end
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign zero_o = (len_q[fo_pkg::QB] == '0);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = v_q[NS-1][i].neg ? fo_pkg::CW'(-{1'b0, quo_q[fo_pkg::QB][i]})
                                   : fo_pkg::CW'(quo_q[fo_pkg::QB][i]);
    end
  end
endmodule

// ===== rtl/fo_cross.sv =====
// Pipelined cross products: backward = right x up, new right = up x backward.
// Depends on fo_pkg.
module fo_cross (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  fo_pkg::in_word_t    word_i,
  output logic                vld_o,
  output fo_pkg::comp_t [2:0] nr_o,
  output fo_pkg::comp_t [2:0] up_o,
  output fo_pkg::comp_t [2:0] bk_o
);
  localparam int P = fo_pkg::PW;
  logic [3:0] vld_q;
  logic signed [fo_pkg::CW-1:0] u_q [4][3];
  logic signed [P:0] p_q [6];
  logic signed [P:0] b_q [3];
  logic signed [fo_pkg::BW:0] n_q [6];
  logic signed [fo_pkg::BW:0] nr_q [3];
  logic signed [P:0] bb_q [3];
  logic signed [fo_pkg::CW-1:0] r [3];
  logic signed [fo_pkg::CW-1:0] u [3];

  assign r = '{word_i.right_x, word_i.right_y, word_i.right_z};
  assign u = '{word_i.up_x, word_i.up_y, word_i.up_z};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u_q[0] <= u;
    u_q[1] <= u_q[0];
    u_q[2] <= u_q[1];
    u_q[3] <= u_q[2];
    p_q[0] <= (P+1)'(r[1] * u[2]);
    p_q[1] <= (P+1)'(r[2] * u[1]);
    p_q[2] <= (P+1)'(r[2] * u[0]);
    p_q[3] <= (P+1)'(r[0] * u[2]);
    p_q[4] <= (P+1)'(r[0] * u[1]);
    p_q[5] <= (P+1)'(r[1] * u[0]);
    for (int i = 0; i < 3; i++) b_q[i] <= p_q[2*i] - p_q[2*i+1];
    n_q[0] <= (fo_pkg::BW+1)'(u_q[1][1] * b_q[2]);
    n_q[1] <= (fo_pkg::BW+1)'(u_q[1][2] * b_q[1]);
    n_q[2] <= (fo_pkg::BW+1)'(u_q[1][2] * b_q[0]);
    n_q[3] <= (fo_pkg::BW+1)'(u_q[1][0] * b_q[2]);
    n_q[4] <= (fo_pkg::BW+1)'(u_q[1][0] * b_q[1]);
    n_q[5] <= (fo_pkg::BW+1)'(u_q[1][1] * b_q[0]);
    bb_q <= b_q;
    for (int i = 0; i < 3; i++) nr_q[i] <= n_q[2*i] - n_q[2*i+1];
  end

  logic signed [P:0] bb2_q [3];
  always_ff @(posedge clk_i) bb2_q <= bb_q;

  assign vld_o = vld_q[3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nr_o[i].neg = nr_q[i][fo_pkg::BW];
      nr_o[i].mag = nr_q[i][fo_pkg::BW] ? fo_pkg::BW'(-nr_q[i]) : fo_pkg::BW'(nr_q[i]);
      up_o[i].neg = u_q[3][i][fo_pkg::CW-1];
      up_o[i].mag = fo_pkg::BW'(u_q[3][i][fo_pkg::CW-1] ? -(fo_pkg::CW+1)'(u_q[3][i])
                                                        : (fo_pkg::CW+1)'(u_q[3][i]));
      bk_o[i].neg = bb2_q[i][P];
      bk_o[i].mag = fo_pkg::BW'(bb2_q[i][P] ? -bb2_q[i] : bb2_q[i]);
    end
  end
endmodule

// ===== rtl/frame_orthonormalize.sv =====
// frame_orthonormalize top: cross products, three normalize lanes, merge.
// Depends on fo_pkg, fo_cross, fo_lane.
// Throughput: one word per cycle; busy_o is always low.
// Reset clears the valid pipeline only; the receiver cannot stall.
module frame_orthonormalize (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  fo_pkg::in_word_t  word_i,
  output logic              strobe_o,
  output fo_pkg::out_word_t word_o
);
  logic cv;
  fo_pkg::comp_t [2:0] nr, up, bk;
  logic [2:0] lv, lz;
  logic [2:0][fo_pkg::CW-1:0] ur, uu, ub;
  logic strobe_q;
  fo_pkg::out_word_t word_q;

  assign busy_o = 1'b0;

  fo_cross u_cross (.clk_i, .rst_ni, .vld_i(start_i), .word_i,
                    .vld_o(cv), .nr_o(nr), .up_o(up), .bk_o(bk));
  fo_lane u_lr (.clk_i, .rst_ni, .vld_i(cv), .vec_i(nr), .vld_o(lv[0]), .zero_o(lz[0]),
                .unit_o(ur));
  fo_lane u_lu (.clk_i, .rst_ni, .vld_i(cv), .vec_i(up), .vld_o(lv[1]), .zero_o(lz[1]),
                .unit_o(uu));
  fo_lane u_lb (.clk_i, .rst_ni, .vld_i(cv), .vec_i(bk), .vld_o(lv[2]), .zero_o(lz[2]),
                .unit_o(ub));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= lv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (|lz) begin
      word_q <= '0;
      word_q.degenerate <= 1'b1;
    end else begin
      word_q <= '{ur[0], ur[1], ur[2], uu[0], uu[1], uu[2], ub[0], ub[1], ub[2], 1'b0};
    end
  end

  assign strobe_o = strobe_q;
  assign word_o = word_q;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lv[0] == lv[1] && lv[1] == lv[2]) else $error("lane valids diverge");
  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lv[0] |=> strobe_o) else $error("strobe lost");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && word_o.degenerate |-> word_o.unit_up_x == '0) else $error("degenerate data");
`endif
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for frame_orthonormalize: drives frames through the command port,
// predicts each normalized frame with exact wide integers and checks every word.
// Depends on fo_pkg and the frame_orthonormalize RTL.
module tb;

  localparam int FRAMES     = 1550;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN      = 120;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  fo_pkg::in_word_t  word_i = '0;
  logic              strobe_o;
  fo_pkg::out_word_t word_o;

  fo_pkg::in_word_t  frames_q[$];
  fo_pkg::out_word_t frames_exp_q[$];
  int        n_total = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_degen = 0;
  int        n_errors = 0;
  int        quiet_cycles = 0;

  frame_orthonormalize uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .word_i  (word_i),
    .strobe_o(strobe_o),
    .word_o  (word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] floor_root(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] c2;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      c2 = {64'd0, c} * {64'd0, c};
      if (c2 <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] mag_sq(longint c);
    logic [63:0] m;
    m = (c < 0) ? 64'(-c) : 64'(c);
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic logic [63:0] vec_length(longint a, longint b, longint c);
    return floor_root(mag_sq(a) + mag_sq(b) + mag_sq(c));
  endfunction

  function automatic logic [fo_pkg::CW-1:0] unit_comp(longint c, logic [63:0] len);
    logic [63:0]  m;
    logic [127:0] q;
    m = (c < 0) ? 64'(-c) : 64'(c);
    q = ({64'd0, m} << fo_pkg::FB) / {64'd0, len};
    return (c < 0) ? fo_pkg::CW'(-q) : fo_pkg::CW'(q);
  endfunction

  function automatic fo_pkg::out_word_t predict_frame(fo_pkg::in_word_t w);
    fo_pkg::out_word_t o;
    longint      rx, ry, rz, ux, uy, uz, bx, by, bz, nx, ny, nz;
    logic [63:0] lr, lu, lb;
    rx = longint'(w.right_x); ry = longint'(w.right_y); rz = longint'(w.right_z);
    ux = longint'(w.up_x);    uy = longint'(w.up_y);    uz = longint'(w.up_z);
    bx = ry * uz - rz * uy;
    by = rz * ux - rx * uz;
    bz = rx * uy - ry * ux;
    nx = uy * bz - uz * by;
    ny = uz * bx - ux * bz;
    nz = ux * by - uy * bx;
    lr = vec_length(nx, ny, nz);
    lu = vec_length(ux, uy, uz);
    lb = vec_length(bx, by, bz);
    o = '0;
    if (lr == 0 || lu == 0 || lb == 0) begin
      o.degenerate = 1'b1;
    end else begin
      o.unit_right_x = unit_comp(nx, lr);
      o.unit_right_y = unit_comp(ny, lr);
      o.unit_right_z = unit_comp(nz, lr);
      o.unit_up_x    = unit_comp(ux, lu);
      o.unit_up_y    = unit_comp(uy, lu);
      o.unit_up_z    = unit_comp(uz, lu);
      o.unit_back_x  = unit_comp(bx, lb);
      o.unit_back_y  = unit_comp(by, lb);
      o.unit_back_z  = unit_comp(bz, lb);
    end
    return o;
  endfunction

  function automatic fo_pkg::in_word_t mk_frame(int rx, int ry, int rz,
                                                int ux, int uy, int uz);
    fo_pkg::in_word_t w;
    w.right_x = fo_pkg::CW'(rx); w.right_y = fo_pkg::CW'(ry); w.right_z = fo_pkg::CW'(rz);
    w.up_x    = fo_pkg::CW'(ux); w.up_y    = fo_pkg::CW'(uy); w.up_z    = fo_pkg::CW'(uz);
    return w;
  endfunction

  function automatic int rnd_comp(int kind);
    case (kind)
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(32) - 16;
      2: return $urandom_range(32768) - 16384;
      default: return ($urandom_range(1)) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
    endcase
  endfunction

  function automatic fo_pkg::in_word_t rnd_frame();
    int kind, k, ux, uy, uz;
    kind = $urandom_range(9);
    if (kind == 9) begin
      // right parallel to upward: degenerate
      k  = $urandom_range(8) - 4;
      ux = $urandom_range(4000) - 2000;
      uy = $urandom_range(4000) - 2000;
      uz = $urandom_range(4000) - 2000;
      return mk_frame(k * ux, k * uy, k * uz, ux, uy, uz);
    end
    kind = (kind < 5) ? 0 : (kind < 7) ? 2 : (kind < 8) ? 1 : 3;
    return mk_frame(rnd_comp(kind), rnd_comp(kind), rnd_comp(kind),
                    rnd_comp(kind), rnd_comp(kind), rnd_comp(kind));
  endfunction

  // driver: idle rate changes with the phase of the run
  always @(negedge clk_i) begin
    int phase, idle_pct;
    phase = (n_sent * 4) / ((n_total > 0) ? n_total : 1);
    idle_pct = (phase == 1) ? 64 : (phase == 3) ? 31 : 0;
    if (rst_ni && frames_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start_i <= 1'b1;
      word_i  <= frames_q[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: accept inputs, check results
  always @(posedge clk_i) begin
    fo_pkg::out_word_t e;
    logic      moved;
    moved = 1'b0;
    if (rst_ni && start_i && !busy_o) begin
      frames_exp_q.push_back(predict_frame(word_i));
      void'(frames_q.pop_front());
      n_sent++;
      moved = 1'b1;
    end
    if (rst_ni && strobe_o) begin
      moved = 1'b1;
      if (frames_exp_q.size() == 0) begin
        $error("unexpected result word %h", word_o);
        n_errors++;
      end else begin
        e = frames_exp_q.pop_front();
        n_checked++;
        if (e.degenerate) n_degen++;
        if (word_o.unit_right_x !== e.unit_right_x) begin
          $error("unit_right_x exp %0d got %0d", e.unit_right_x, word_o.unit_right_x); n_errors++;
        end
        if (word_o.unit_right_y !== e.unit_right_y) begin
          $error("unit_right_y exp %0d got %0d", e.unit_right_y, word_o.unit_right_y); n_errors++;
        end
        if (word_o.unit_right_z !== e.unit_right_z) begin
          $error("unit_right_z exp %0d got %0d", e.unit_right_z, word_o.unit_right_z); n_errors++;
        end
        if (word_o.unit_up_x !== e.unit_up_x) begin
          $error("unit_up_x exp %0d got %0d", e.unit_up_x, word_o.unit_up_x); n_errors++;
        end
        if (word_o.unit_up_y !== e.unit_up_y) begin
          $error("unit_up_y exp %0d got %0d", e.unit_up_y, word_o.unit_up_y); n_errors++;
        end
        if (word_o.unit_up_z !== e.unit_up_z) begin
          $error("unit_up_z exp %0d got %0d", e.unit_up_z, word_o.unit_up_z); n_errors++;
        end
        if (word_o.unit_back_x !== e.unit_back_x) begin
          $error("unit_back_x exp %0d got %0d", e.unit_back_x, word_o.unit_back_x); n_errors++;
        end
        if (word_o.unit_back_y !== e.unit_back_y) begin
          $error("unit_back_y exp %0d got %0d", e.unit_back_y, word_o.unit_back_y); n_errors++;
        end
        if (word_o.unit_back_z !== e.unit_back_z) begin
          $error("unit_back_z exp %0d got %0d", e.unit_back_z, word_o.unit_back_z); n_errors++;
        end
        if (word_o.degenerate !== e.degenerate) begin
          $error("degenerate exp %0b got %0b", e.degenerate, word_o.degenerate); n_errors++;
        end
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d frames pending, %0d words outstanding",
               frames_q.size(), frames_exp_q.size());
      $display("frame_orthonormalize verification failed");
      $finish;
    end
  end

  initial begin
    // directed frames
    frames_q.push_back(mk_frame(16384, 0, 0, 0, 16384, 0));
    frames_q.push_back(mk_frame(0, 0, 16384, 16384, 0, 0));
    frames_q.push_back(mk_frame(0, 0, 0, 0, 0, 0));
    frames_q.push_back(mk_frame(100, 200, 300, 0, 0, 0));
    frames_q.push_back(mk_frame(0, 0, 0, 5, -7, 9));
    frames_q.push_back(mk_frame(3, -6, 9, -1, 2, -3));
    frames_q.push_back(mk_frame(-32768, -32768, -32768, -32768, -32768, -32768));
    frames_q.push_back(mk_frame(32767, 32767, 32767, 32767, 32767, 32767));
    frames_q.push_back(mk_frame(-32768, 0, 0, 0, -32768, 0));
    frames_q.push_back(mk_frame(32767, -32768, 32767, -32768, 32767, -32768));
    frames_q.push_back(mk_frame(-32768, 32767, 0, 32767, 32767, -32768));
    frames_q.push_back(mk_frame(32767, 0, 0, 0, 0, -32768));
    frames_q.push_back(mk_frame(1, 0, 0, 0, 1, 0));
    frames_q.push_back(mk_frame(-1, 0, 0, 0, 0, -1));
    frames_q.push_back(mk_frame(1, 1, 0, 0, 1, 1));
    frames_q.push_back(mk_frame(16384, 16384, 0, -16384, 16384, 0));
    frames_q.push_back(mk_frame(-1, -1, -1, 1, 0, 0));
    frames_q.push_back(mk_frame(12345, -23456, 31000, -30000, 1, 22222));
    frames_q.push_back(mk_frame(-32768, -32768, -32768, 32767, 32767, 32767));
    frames_q.push_back(mk_frame(21845, -10922, 5461, -5461, 10922, -21845));
    while (frames_q.size() < FRAMES) frames_q.push_back(rnd_frame());
    n_total = frames_q.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (frames_q.size() == 0 && frames_exp_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);

    $display("frames sent %0d, words checked %0d (%0d degenerate), in four idle phases",
             n_sent, n_checked, n_degen);
    if (n_errors == 0 && frames_exp_q.size() == 0) begin
      $display("frame_orthonormalize verification clean");
    end else begin
      $display("frame_orthonormalize verification failed");
    end
    $finish;
  end

endmodule
